// ===== design/rbfp_pkg.sv =====
`timescale 1ns / 1ps

package rbfp_pkg;

   // bank geometry
   localparam int INDEX_WIDTH = 16;
   localparam int BANK_DEPTH  = 1 << INDEX_WIDTH;

   // word field widths
   localparam int HASH_WIDTH = 64;
   localparam int HALF_WIDTH = 32;
   localparam int FUNC_WIDTH = 2;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef logic [FUNC_WIDTH-1:0]  func_type;
   typedef logic [HASH_WIDTH-1:0]  hash_type;
   typedef logic [INDEX_WIDTH-1:0] pos_type;

   // operation codes
   localparam func_type FUNC_ADD  = 2'd0;
   localparam func_type FUNC_TEST = 2'd1;
   localparam func_type FUNC_SWAP = 2'd2;

   // classified command
   typedef struct packed {
      func_type func;
      pos_type  pos_a;
      pos_type  pos_b;
   } cmd_type;

   // queue head as seen by the back part
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // back part status towards the front part
   typedef struct packed {
      logic pop;
      logic accepting;
   } back_status_type;

endpackage

// ===== design/rbfp_if.sv =====
`timescale 1ns / 1ps

// request channel
interface rbfp_req_if;
   import rbfp_pkg::*;

   logic     valid;
   logic     ready;
   func_type func;
   hash_type key_hash;

   modport source (output valid, output func, output key_hash, input ready);
   modport sink (input valid, input func, input key_hash, output ready);
endinterface

// response channel
interface rbfp_rsp_if;
   import rbfp_pkg::*;

   logic     valid;
   logic     ready;
   func_type done_func;
   logic     maybe_present;

   modport source (output valid, output done_func, output maybe_present, input ready);
   modport sink (input valid, input done_func, input maybe_present, output ready);
endinterface

// ===== design/rbfp_ram.sv =====
`timescale 1ns / 1ps

module rbfp_ram #(
   parameter int DATA_WIDTH = 1,
   parameter int DEPTH      = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0]            wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0]            rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rbfp_front.sv =====
`timescale 1ns / 1ps

module rbfp_front (
   input  logic                     clock,
   input  logic                     reset,
   rbfp_req_if.sink                 req_ch,
   input  rbfp_pkg::back_status_type status,
   output rbfp_pkg::queue_head_type head
);
   import rbfp_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   push;
   cmd_type                cmd;

   // split the hash into the two probe positions
   always_comb begin
      cmd.func  = req_ch.func;
      cmd.pos_a = req_ch.key_hash[HALF_WIDTH +: INDEX_WIDTH];
      cmd.pos_b = req_ch.key_hash[INDEX_WIDTH-1:0];
   end

   // take a word while there is room and the banks are initialised
   assign req_ch.ready = status.accepting &&
                         (count_ff != QUEUE_DEPTH[QUEUE_PTR_W:0]);
   assign push         = req_ch.valid && req_ch.ready;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = status.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !status.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && status.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

endmodule

// ===== design/rbfp_back.sv =====
`timescale 1ns / 1ps

module rbfp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rbfp_pkg::queue_head_type  head,
   output rbfp_pkg::back_status_type status,
   rbfp_rsp_if.source                rsp_ch
);
   import rbfp_pkg::*;

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_ADD    = 7'b0000100,
      ST_TEST_B = 7'b0001000,
      ST_TEST_C = 7'b0010000,
      ST_CLEAR  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      back_active_ff, back_active_in;
   logic      clear_back_ff, clear_back_in;
   pos_type   cnt_ff, cnt_in;
   logic      hit_a_ff, hit_a_in;
   logic      rsp_valid_ff, rsp_valid_in;
   func_type  rsp_func_ff, rsp_func_in;
   logic      rsp_hit_ff, rsp_hit_in;

   logic      front_we, back_we;
   pos_type   front_waddr, back_waddr;
   logic      front_wdata, back_wdata;
   pos_type   rd_addr;
   logic      front_rdata, back_rdata;
   logic      active_rdata;
   logic      out_free;
   logic      pop;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign active_rdata = back_active_ff ? back_rdata : front_rdata;

   // sequencer over the two bank memories
   always_comb begin
      state_in       = state_ff;
      back_active_in = back_active_ff;
      clear_back_in  = clear_back_ff;
      cnt_in         = cnt_ff;
      hit_a_in       = hit_a_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_func_in    = rsp_func_ff;
      rsp_hit_in     = rsp_hit_ff;
      front_we       = 1'b0;
      back_we        = 1'b0;
      front_waddr    = head.cmd.pos_a;
      back_waddr     = head.cmd.pos_a;
      front_wdata    = 1'b1;
      back_wdata     = 1'b1;
      rd_addr        = head.cmd.pos_a;
      pop            = 1'b0;

      case (state_ff)
         ST_INIT: begin
            // after reset: front bank to ones, back bank to zeros
            front_we    = 1'b1;
            back_we     = 1'b1;
            front_waddr = cnt_ff;
            back_waddr  = cnt_ff;
            front_wdata = 1'b1;
            back_wdata  = 1'b0;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               case (head.cmd.func)
                  FUNC_ADD: begin
                     front_we = 1'b1;
                     back_we  = 1'b1;
                     state_in = ST_ADD;
                  end
                  FUNC_TEST: begin
                     state_in = ST_TEST_B;
                  end
                  FUNC_SWAP: begin
                     clear_back_in  = back_active_ff;
                     back_active_in = !back_active_ff;
                     cnt_in         = '0;
                     state_in       = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_ADD: begin
            // second probe
            front_we    = 1'b1;
            back_we     = 1'b1;
            front_waddr = head.cmd.pos_b;
            back_waddr  = head.cmd.pos_b;
            state_in    = ST_FINISH;
         end
         ST_TEST_B: begin
            // first probe bit arrives, second probe read issued
            rd_addr  = head.cmd.pos_b;
            hit_a_in = active_rdata;
            state_in = ST_TEST_C;
         end
         ST_TEST_C: begin
            // hold the read address so the second bit stays put while stalled
            rd_addr = head.cmd.pos_b;
            if (out_free) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_func_in  = head.cmd.func;
               rsp_hit_in   = hit_a_ff & active_rdata;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            // sweep the bank that has just gone idle
            front_we    = !clear_back_ff;
            back_we     = clear_back_ff;
            front_waddr = cnt_ff;
            back_waddr  = cnt_ff;
            front_wdata = 1'b0;
            back_wdata  = 1'b0;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_func_in  = head.cmd.func;
               rsp_hit_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         back_active_ff <= 1'b0;
         clear_back_ff  <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         back_active_ff <= back_active_in;
         clear_back_ff  <= clear_back_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_a_ff    <= hit_a_in;
      rsp_func_ff <= rsp_func_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   // bank memories
   rbfp_ram #(
      .DATA_WIDTH (1),
      .DEPTH      (BANK_DEPTH)
   ) u_front_bank (
      .clock   (clock),
      .wr_en   (front_we),
      .wr_addr (front_waddr),
      .wr_data (front_wdata),
      .rd_addr (rd_addr),
      .rd_data (front_rdata)
   );

   rbfp_ram #(
      .DATA_WIDTH (1),
      .DEPTH      (BANK_DEPTH)
   ) u_back_bank (
      .clock   (clock),
      .wr_en   (back_we),
      .wr_addr (back_waddr),
      .wr_data (back_wdata),
      .rd_addr (rd_addr),
      .rd_data (back_rdata)
   );

   assign status.pop       = pop;
   assign status.accepting = (state_ff != ST_INIT);

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.done_func     = rsp_func_ff;
   assign rsp_ch.maybe_present = rsp_hit_ff;

   // checks
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

   a_pop_gives_word: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("completed command produced no response word");

   a_clear_idle_bank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (clear_back_ff != back_active_ff))
      else $error("sweep is clearing the active bank");

   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !pop)
      else $error("command completed during initial sweep");

endmodule

// ===== design/rotating_bloom_filter_pair.sv =====
`timescale 1ns / 1ps

// Double-buffered Bloom filter with two probes per key, held in two 2^16 x 1
// bank memories with one write and one read port each. Each request word
// carries an operation and a precomputed 64-bit hash; the probes are the low
// 16 bits of each 32-bit half. Every request gives exactly one response word.
// After reset the block runs an initialisation sweep (front bank
// to ones, back bank to zeros) and takes no request until it is done. A
// two-entry command queue sits between the request side and the bank
// sequencer, and a response register sits on the output, so one request can
// be queued while another runs and a finished response waits. In the
// sequencer: add writes each probe, then the response; test makes two reads
// through the registered read port, the second issued as the first returns,
// then the response; an unused code goes straight to the response; swap
// clears the formerly active bank one entry per cycle, then the response.
module rotating_bloom_filter_pair (
   input  logic       clock,
   input  logic       reset,
   rbfp_req_if.sink   req_ch,
   rbfp_rsp_if.source rsp_ch
);
   import rbfp_pkg::*;

   queue_head_type  head;
   back_status_type status;

   // accept and classify
   rbfp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .status (status),
      .head   (head)
   );

   // bank sequencer and response register
   rbfp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .status (status),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import rbfp_pkg::*;

   // opcode with no operation behind it
   localparam func_type FUNC_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS   = 1880;
   localparam int MAX_RAND_SWAPS = 6;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 50;
   // a swap clears a whole bank, so allow several sweeps of dead time
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int POOL_DEPTH     = 64;

   typedef struct packed {
      func_type done_func;
      logic     maybe_present;
   } outcome_t;

   typedef struct packed {
      func_type func;
      hash_type key_hash;
      logic     typed;
      outcome_t want;
   } stim_row_t;

   logic clock;
   logic reset;

   rbfp_req_if req_ch ();
   rbfp_rsp_if rsp_ch ();

   rotating_bloom_filter_pair DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // filter shadow state
   bit [BANK_DEPTH-1:0] front_copy;
   bit [BANK_DEPTH-1:0] back_copy;
   bit                  back_live;

   outcome_t expected_outcomes[$];
   hash_type added_keys[$];
   int       mismatches;
   int       req_idle_pct;
   int       rsp_stall_pct;
   bit       hold_pending;

   // directed words: expectation typed in only where it is obvious
   stim_row_t directed_rows [21] = '{
      '{FUNC_TEST,   64'h0000_0000_0000_0000, 1'b1, '{FUNC_TEST, 1'b1}},
      '{FUNC_TEST,   64'hffff_ffff_ffff_ffff, 1'b1, '{FUNC_TEST, 1'b1}},
      '{FUNC_ADD,    64'h0000_0001_0000_0002, 1'b1, '{FUNC_ADD, 1'b0}},
      '{FUNC_ADD,    64'hffff_ffff_ffff_ffff, 1'b1, '{FUNC_ADD, 1'b0}},
      '{FUNC_ADD,    64'h1234_abcd_5678_abcd, 1'b1, '{FUNC_ADD, 1'b0}},
      '{FUNC_UNUSED, 64'h0123_4567_89ab_cdef, 1'b1, '{FUNC_UNUSED, 1'b0}},
      '{FUNC_SWAP,   64'h0000_0000_0000_0000, 1'b1, '{FUNC_SWAP, 1'b0}},
      '{FUNC_TEST,   64'h0000_0001_0000_0002, 1'b0, '{FUNC_TEST, 1'b0}},
      '{FUNC_TEST,   64'hffff_ffff_ffff_ffff, 1'b0, '{FUNC_TEST, 1'b0}},
      '{FUNC_TEST,   64'h0000_abcd_0000_abcd, 1'b0, '{FUNC_TEST, 1'b0}},
      '{FUNC_TEST,   64'h0000_0001_0000_0003, 1'b0, '{FUNC_TEST, 1'b0}},
      '{FUNC_TEST,   64'h0000_0000_0000_0000, 1'b0, '{FUNC_TEST, 1'b0}},
      '{FUNC_ADD,    64'h8000_0000_8000_0000, 1'b1, '{FUNC_ADD, 1'b0}},
      '{FUNC_TEST,   64'h0000_0000_0000_0000, 1'b0, '{FUNC_TEST, 1'b0}},
      '{FUNC_UNUSED, 64'hffff_ffff_ffff_ffff, 1'b1, '{FUNC_UNUSED, 1'b0}},
      '{FUNC_SWAP,   64'hffff_ffff_ffff_ffff, 1'b1, '{FUNC_SWAP, 1'b0}},
      '{FUNC_TEST,   64'h0000_0001_0000_0002, 1'b0, '{FUNC_TEST, 1'b0}},
      '{FUNC_TEST,   64'h5555_0000_aaaa_0000, 1'b0, '{FUNC_TEST, 1'b0}},
      '{FUNC_ADD,    64'haaaa_aaaa_5555_5555, 1'b1, '{FUNC_ADD, 1'b0}},
      '{FUNC_TEST,   64'haaaa_aaaa_5555_5555, 1'b0, '{FUNC_TEST, 1'b0}},
      '{FUNC_TEST,   64'h5555_5555_aaaa_aaaa, 1'b0, '{FUNC_TEST, 1'b0}}
   };

   // work out the response for one word and update the shadow banks
   function automatic outcome_t bloom_predict(func_type f, hash_type h);
      pos_type  pa;
      pos_type  pb;
      outcome_t o;
      pa = h[HALF_WIDTH +: INDEX_WIDTH];
      pb = h[INDEX_WIDTH-1:0];
      o.done_func     = f;
      o.maybe_present = 1'b0;
      case (f)
         FUNC_ADD: begin
            front_copy[pa] = 1'b1;
            front_copy[pb] = 1'b1;
            back_copy[pa]  = 1'b1;
            back_copy[pb]  = 1'b1;
         end
         FUNC_TEST: begin
            if (back_live)
               o.maybe_present = back_copy[pa] & back_copy[pb];
            else
               o.maybe_present = front_copy[pa] & front_copy[pb];
         end
         FUNC_SWAP: begin
            if (back_live) begin
               back_live = 1'b0;
               back_copy = '0;
            end else begin
               back_live  = 1'b1;
               front_copy = '0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // random hash, sometimes with both probes on the same position
   function automatic hash_type random_hash();
      hash_type h;
      h = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0)
         h[HALF_WIDTH +: INDEX_WIDTH] = h[INDEX_WIDTH-1:0];
      return h;
   endfunction

   task automatic set_idling(int phase);
      case (phase)
         0: begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            req_idle_pct  = 46;
            rsp_stall_pct = 0;
         end
         2: begin
            req_idle_pct  = 0;
            rsp_stall_pct = 46;
         end
         default: begin
            req_idle_pct  = 37;
            rsp_stall_pct = 37;
         end
      endcase
   endtask

   // offer one request word, queue its expectation once taken
   task automatic offer_word(func_type f, hash_type h, logic typed, outcome_t want);
      outcome_t model_out;
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.func     <= f;
      req_ch.key_hash <= h;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      model_out = bloom_predict(f, h);
      expected_outcomes.push_back(typed ? want : model_out);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // stimulus
   initial begin
      int       swaps_left;
      int       r;
      func_type f;
      hash_type h;
      outcome_t none;

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.func     = FUNC_ADD;
      req_ch.key_hash = '0;
      front_copy      = '1;
      back_copy       = '0;
      back_live       = 1'b0;
      mismatches      = 0;
      hold_pending    = 1'b0;
      swaps_left      = MAX_RAND_SWAPS;
      none            = '{FUNC_ADD, 1'b0};
      set_idling(0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i])
         offer_word(directed_rows[i].func, directed_rows[i].key_hash,
                    directed_rows[i].typed, directed_rows[i].want);

      // random words, mostly adds and tests, with many tests on recently added keys
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         set_idling((i / 150) % 4);
         if (i == 0)
            hold_pending = 1'b1;
         r = $urandom_range(0, 999);
         h = random_hash();
         if (r < 3 && swaps_left > 0) begin
            f = FUNC_SWAP;
            swaps_left--;
         end else if (r < 40) begin
            f = FUNC_UNUSED;
         end else if (r < 480) begin
            f = FUNC_ADD;
            added_keys.push_back(h);
            if (added_keys.size() > POOL_DEPTH)
               void'(added_keys.pop_front());
         end else begin
            f = FUNC_TEST;
            if (added_keys.size() > 0 && $urandom_range(0, 9) < 6)
               h = added_keys[$urandom_range(0, added_keys.size() - 1)];
         end
         offer_word(f, h, 1'b0, none);
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;
      set_idling(0);

      // drain
      while (expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_outcomes.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // response side ready, with one long hold-off to back the block up
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      outcome_t exp_word;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_outcomes.size() == 0) begin
            $error("response word with nothing expected: done_func %0d", rsp_ch.done_func);
            mismatches++;
         end else begin
            exp_word = expected_outcomes.pop_front();
            if (rsp_ch.done_func !== exp_word.done_func) begin
               $error("done_func: expected %0d, actual %0d",
                      exp_word.done_func, rsp_ch.done_func);
               mismatches++;
            end
            if (rsp_ch.maybe_present !== exp_word.maybe_present) begin
               $error("maybe_present: expected %0d, actual %0d",
                      exp_word.maybe_present, rsp_ch.maybe_present);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving either way
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stuck = 0;
         else
            stuck++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
